FILE: sv/hgt_pkg.sv
package hgt_pkg;

  // Grid geometry
  localparam int GRID_CELLS = 100;
  localparam int CELL_MM    = 100;
  localparam int HALF_MM    = GRID_CELLS * CELL_MM / 2;
  localparam int BOUND_MM   = HALF_MM - 10;
  localparam int NUM_CELLS  = GRID_CELLS * GRID_CELLS;
  localparam int CELL_W     = $clog2(NUM_CELLS);
  localparam int ROW_W      = $clog2(GRID_CELLS);
  localparam int OFF_W      = $clog2(2 * HALF_MM);

  // Floor division by the cell size through a scaled reciprocal.
  localparam int DIV_SHIFT  = 24;
  localparam int DIV_RECIP  = (2 ** DIV_SHIFT + CELL_MM - 1) / CELL_MM;

  // Bogus-point test: squared sensor distance below this is dropped.
  localparam int MIN_DIST_SQ = 100;

  // Height span table
  localparam int SPAN_TABLE_SIZE = 256;
  localparam int SPAN_W          = $clog2(SPAN_TABLE_SIZE);
  localparam int KNEE_START      = 50;
  localparam int KNEE_LEN        = 17;
  localparam logic [7:0] KNEE [KNEE_LEN] = '{
    8'd254, 8'd254, 8'd252, 8'd248, 8'd241, 8'd227, 8'd201, 8'd162, 8'd115,
    8'd71, 8'd40, 8'd21, 8'd11, 8'd5, 8'd3, 8'd1, 8'd1
  };

  // Count saturation
  localparam logic [7:0] COUNT_MAX = 8'd255;

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_LIMIT     = 1'b0,
    REG_COUNT_THRESHOLD = 1'b1
  } cfg_reg_t;

  localparam logic [14:0] RANGE_LIMIT_RESET     = 15'd5000;
  localparam logic [7:0]  COUNT_THRESHOLD_RESET = 8'd10;

  typedef struct packed {
    logic signed [15:0] sensor_x;
    logic signed [15:0] sensor_y;
    logic signed [15:0] robot_x;
    logic signed [15:0] robot_y;
    logic signed [15:0] map_x;
    logic signed [15:0] map_y;
    logic signed [15:0] map_z;
  } point_t;

  typedef struct packed {
    logic [6:0] cell_row;
    logic [6:0] cell_col;
    logic [7:0] traversability;
  } result_t;

  function automatic logic [7:0] span_lookup(input logic [SPAN_W-1:0] span);
    logic [SPAN_W-1:0] off;
    logic [7:0]        val;
    off = span - SPAN_W'(KNEE_START);
    if (span < SPAN_W'(KNEE_START)) begin
      val = 8'd255;
    end else if (off < SPAN_W'(KNEE_LEN)) begin
      val = KNEE[off[$clog2(KNEE_LEN)-1:0]];
    end else begin
      val = 8'd0;
    end
    return val;
  endfunction

endpackage

FILE: sv/height_grid_traversability_core.sv
// Height-grid traversability core. Takes one point per clock cycle while
// pt_stall is low; the grid state sits in a single-port-write, registered-read
// memory and is updated by a read-modify-write that forwards the previous
// write, so back-to-back points on the same cell are exact. A kept point
// whose cell count exceeds the count threshold yields a result through stages
// A, B and C and an eight-entry result queue; the input stalls during the
// clearing pass and when that queue cannot take what is in flight. After reset
// the block clears all 10000 grid cells, one per cycle, stalling the point input
// until done; configuration writes are taken at any time the block is idle.
module height_grid_traversability_core
  import hgt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pt_valid,
  output logic                  pt_stall,
  input  point_t                pt,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PROD_W = OFF_W + DIV_SHIFT;

  typedef struct packed {
    logic [7:0]         cnt;
    logic signed [15:0] min_h;
    logic signed [15:0] max_h;
  } entry_t;

  // Configuration
  logic [14:0] range_limit;
  logic [7:0]  count_threshold;
  logic [29:0] lim_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_limit     <= RANGE_LIMIT_RESET;
      count_threshold <= COUNT_THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RANGE_LIMIT:     range_limit     <= cfg_data[14:0];
        REG_COUNT_THRESHOLD: count_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lim_sq <= 30'(range_limit) * 30'(range_limit);
  end

  // Clearing pass
  logic              clearing;
  logic [CELL_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == CELL_W'(NUM_CELLS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Stage A: squares, window test, cell coordinates
  logic                     pt_accept;
  logic signed [31:0]       sxp, syp, rxp, ryp;
  logic signed [16:0]       vx, vy;
  logic [PROD_W-1:0]        row_prod, col_prod;
  logic                     in_win;

  logic                     a_valid;
  logic [31:0]              a_sxx, a_syy, a_rxx, a_ryy;
  logic                     a_win;
  logic [ROW_W-1:0]         a_row, a_col;
  logic signed [15:0]       a_z;

  assign pt_accept = pt_valid && !pt_stall;
  assign sxp = 32'(pt.sensor_x) * 32'(pt.sensor_x);
  assign syp = 32'(pt.sensor_y) * 32'(pt.sensor_y);
  assign rxp = 32'(pt.robot_x) * 32'(pt.robot_x);
  assign ryp = 32'(pt.robot_y) * 32'(pt.robot_y);
  assign vx  = 17'(pt.map_x) + 17'(HALF_MM);
  assign vy  = 17'(pt.map_y) + 17'(HALF_MM);
  assign row_prod = PROD_W'(vx[OFF_W-1:0]) * PROD_W'(DIV_RECIP);
  assign col_prod = PROD_W'(vy[OFF_W-1:0]) * PROD_W'(DIV_RECIP);
  assign in_win = (pt.map_x > -16'(BOUND_MM)) && (pt.map_x < 16'(BOUND_MM)) &&
                  (pt.map_y > -16'(BOUND_MM)) && (pt.map_y < 16'(BOUND_MM));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= pt_accept;
    end
    a_sxx <= $unsigned(sxp);
    a_syy <= $unsigned(syp);
    a_rxx <= $unsigned(rxp);
    a_ryy <= $unsigned(ryp);
    a_win <= in_win;
    a_row <= row_prod[DIV_SHIFT +: ROW_W];
    a_col <= col_prod[DIV_SHIFT +: ROW_W];
    a_z   <= pt.map_z;
  end

  // Filter decision and memory read
  logic              keep;
  logic [CELL_W-1:0] a_idx;

  assign keep = a_win &&
                ({1'b0, a_sxx} + {1'b0, a_syy} >= 33'(MIN_DIST_SQ)) &&
                ({1'b0, a_rxx} + {1'b0, a_ryy} <= 33'(lim_sq));
  assign a_idx = CELL_W'(a_row) * CELL_W'(GRID_CELLS) + CELL_W'(a_col);

  entry_t grid_mem [NUM_CELLS];
  entry_t rd_q;

  // Stage B: merge the point into its cell and write back
  logic               b_valid;
  logic [CELL_W-1:0]  b_idx;
  logic [ROW_W-1:0]   b_row, b_col;
  logic signed [15:0] b_z;

  logic               wr_valid;
  logic [CELL_W-1:0]  wr_idx;
  entry_t             wr_word;

  entry_t             cur, upd;

  always_comb begin
    // The previous point's write lands at the same edge this read was taken.
    cur = (wr_valid && wr_idx == b_idx) ? wr_word : rd_q;
    upd = cur;
    if (cur.cnt == 8'd0) begin
      upd.min_h = b_z;
      upd.max_h = b_z;
    end else begin
      if (b_z < cur.min_h) upd.min_h = b_z;
      if (b_z > cur.max_h) upd.max_h = b_z;
    end
    if (cur.cnt != COUNT_MAX) begin
      upd.cnt = cur.cnt + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= grid_mem[a_idx];
    if (clearing) begin
      grid_mem[clr_addr] <= '0;
    end else if (b_valid) begin
      grid_mem[b_idx] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid  <= 1'b0;
      wr_valid <= 1'b0;
    end else begin
      b_valid  <= a_valid && keep;
      wr_valid <= b_valid;
    end
    b_idx   <= a_idx;
    b_row   <= a_row;
    b_col   <= a_col;
    b_z     <= a_z;
    wr_idx  <= b_idx;
    wr_word <= upd;
  end

  // Stage C: threshold and span lookup
  logic               c_valid;
  logic [ROW_W-1:0]   c_row, c_col;
  entry_t             c_ent;
  logic signed [16:0] c_span;
  logic [SPAN_W-1:0]  c_span_sat;
  logic               c_emit;
  result_t            c_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
    c_row <= b_row;
    c_col <= b_col;
    c_ent <= upd;
  end

  always_comb begin
    c_span = 17'(c_ent.max_h) - 17'(c_ent.min_h);
    if (c_span > 17'(SPAN_TABLE_SIZE - 1)) begin
      c_span_sat = SPAN_W'(SPAN_TABLE_SIZE - 1);
    end else begin
      c_span_sat = c_span[SPAN_W-1:0];
    end
    c_emit               = c_valid && (c_ent.cnt > count_threshold);
    c_res.cell_row       = 7'(c_row);
    c_res.cell_col       = 7'(c_col);
    c_res.traversability = span_lookup(c_span_sat);
  end

  // Result queue
  result_t            fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   fifo_cnt;
  logic               fifo_pop;
  logic [FIFO_AW+1:0] in_flight;

  assign result_valid = (fifo_cnt != '0);
  assign result       = fifo_mem[rd_ptr];
  assign fifo_pop     = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      if (c_emit) wr_ptr <= wr_ptr + 1'b1;
      if (fifo_pop) rd_ptr <= rd_ptr + 1'b1;
      if (c_emit && !fifo_pop) begin
        fifo_cnt <= fifo_cnt + 1'b1;
      end else if (!c_emit && fifo_pop) begin
        fifo_cnt <= fifo_cnt - 1'b1;
      end
    end
    if (c_emit) begin
      fifo_mem[wr_ptr] <= c_res;
    end
  end

  // Every point in the pipeline may still need a queue slot.
  assign in_flight = (FIFO_AW + 2)'(fifo_cnt) + (FIFO_AW + 2)'(a_valid) +
                     (FIFO_AW + 2)'(b_valid) + (FIFO_AW + 2)'(c_valid);
  assign pt_stall  = clearing || (in_flight >= (FIFO_AW + 2)'(FIFO_DEPTH));

endmodule
